// ===== rtl/chbd_pkg.sv =====
package chbd_pkg;

    localparam int MaxSymbols = 288;
    localparam int MaxLength  = 15;
    localparam int SymW       = 9;
    localparam int AddrW      = $clog2(MaxSymbols);
    localparam int CntW       = $clog2(MaxSymbols + 1);

    localparam logic [2:0] ST_LOADED  = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_BAD_SET = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_NO_CODE = 3'd4;

    typedef struct packed {
        logic        op;
        logic [3:0]  code_length;
        logic        last_length;
        logic [14:0] bit_window;
    } t_item;

    typedef struct packed {
        logic [3:0]  bits_used;
        logic [8:0]  symbol;
        logic [2:0]  status;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_CHECK,
        S_PLACE,
        S_DEC_RD,
        S_OUT
    } t_state;

endpackage

// ===== rtl/chbd_ram.sv =====
module chbd_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/chbd_front.sv =====
// Input skid queue: two entries, lets the back part stall independently.
module chbd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  chbd_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output chbd_pkg::t_item o_item
);
    import chbd_pkg::*;

    t_item      r_q [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/chbd_back.sv =====
// Executes loads, table builds and decodes one word at a time.
module chbd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  chbd_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output chbd_pkg::t_result o_res
);
    import chbd_pkg::*;

    t_state r_state, n_state;
    logic [3:0]      r_maxlen;
    logic [CntW-1:0] r_load_cnt;
    logic [CntW-1:0] r_n;
    logic [CntW-1:0] r_idx;
    logic [SymW-1:0] r_cnt   [16];
    logic [15:0]     r_first [16];
    logic [SymW-1:0] r_slot  [16];
    logic [SymW:0]   r_fill  [16];
    logic            r_code_valid;
    logic            r_bad;
    logic            r_rd_pend;
    logic [3:0]      r_len;
    logic [SymW-1:0] r_rsym;
    t_result         r_res;
    logic            r_out_valid;
    logic [2:0]      r_status;
    logic [3:0]      r_used;
    logic            r_ssl_ok;

    // length store
    logic            len_we;
    logic [AddrW-1:0] len_waddr, len_raddr;
    logic [3:0]      len_rdata;
    // sorted symbols
    logic            sym_we;
    logic [AddrW-1:0] sym_waddr, sym_raddr;
    logic [SymW-1:0] sym_rdata;

    chbd_ram #(.Width(4), .Depth(MaxSymbols)) u_len (
        .i_clk(i_clk), .i_we(len_we), .i_waddr(len_waddr), .i_wdata(i_item.code_length),
        .i_raddr(len_raddr), .o_rdata(len_rdata)
    );
    chbd_ram #(.Width(SymW), .Depth(MaxSymbols)) u_sym (
        .i_clk(i_clk), .i_we(sym_we), .i_waddr(sym_waddr), .i_wdata(r_rsym),
        .i_raddr(sym_raddr), .o_rdata(sym_rdata)
    );

    logic take;
    logic [3:0] limit;
    assign limit = (r_maxlen < 4'(MaxLength)) ? r_maxlen : 4'(MaxLength);
    assign take  = i_valid && o_ready;

    assign len_we    = take && !i_item.op && (r_load_cnt < CntW'(MaxSymbols));
    assign len_waddr = r_load_cnt[AddrW-1:0];
    assign len_raddr = r_idx[AddrW-1:0];

    // place pass: r_len/r_rsym hold the previous read's length and symbol
    logic [SymW:0] pfill;
    assign pfill     = r_fill[r_len];
    assign sym_we    = (r_state == S_PLACE) && (r_len != 4'd0) &&
                       (pfill < (SymW+1)'(MaxSymbols));
    assign sym_waddr = pfill[AddrW-1:0];

    // completeness check over 15 lengths, one per cycle
    logic [16:0] r_space;
    logic        r_over;
    logic [SymW:0] r_present;

    // decode compare for one length per cycle
    logic [15:0] r_code;
    logic [14:0] r_win;
    logic [15:0] dcode;
    logic [15:0] ddiff;
    logic        dhit;
    logic [SymW-1:0] dslot;
    assign dcode = {r_code[14:0], r_win[r_len - 4'd1]};
    assign ddiff = dcode - r_first[r_len];
    assign dhit  = (dcode >= r_first[r_len]) && (ddiff < 16'(r_cnt[r_len]));
    assign dslot = r_slot[r_len] + ddiff[SymW-1:0];
    // symbol read issued on the hit cycle, data ready in S_OUT
    assign sym_raddr = dslot[AddrW-1:0];

    assign o_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (take) begin
                if (!i_item.op) n_state = i_item.last_length ? S_COUNT : S_IDLE;
                else n_state = r_code_valid ? S_DEC_RD : S_IDLE;
            end
            S_COUNT:  if (r_bad || (r_rd_pend && r_idx == r_n)) n_state = r_bad ? S_OUT : S_CHECK;
            S_CHECK:  if (r_len == 4'd15) n_state = S_PLACE;
            S_PLACE:  if (!r_rd_pend && r_idx == r_n) n_state = S_OUT;
            S_DEC_RD: if (dhit || r_len == 4'(MaxLength)) n_state = dhit ? S_OUT : S_IDLE;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_maxlen     <= 4'd15;
            r_load_cnt   <= '0;
            r_code_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < 16; k++) begin
                r_cnt[k]   <= '0;
                r_first[k] <= '0;
                r_slot[k]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_maxlen <= i_cfg_data;
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (take) begin
                    r_idx     <= '0;
                    r_rd_pend <= 1'b0;
                    r_bad     <= 1'b0;
                    r_present <= '0;
                    r_len     <= 4'd1;
                    r_code    <= '0;
                    r_win     <= i_item.bit_window;
                    if (!i_item.op) begin
                        if (r_load_cnt < CntW'(MaxSymbols)) begin
                            r_load_cnt <= r_load_cnt + CntW'(1);
                            r_n        <= r_load_cnt + CntW'(1);
                        end else begin
                            r_n <= r_load_cnt;
                        end
                        if (i_item.last_length) begin
                            for (int k = 0; k < 16; k++) r_fill[k] <= '0;
                        end else begin
                            r_res       <= '{bits_used: 4'd0, symbol: '0, status: ST_LOADED};
                            r_out_valid <= 1'b1;
                        end
                    end else if (!r_code_valid) begin
                        r_res       <= '{bits_used: 4'd0, symbol: '0, status: ST_NO_CODE};
                        r_out_valid <= 1'b1;
                    end
                end
                S_COUNT: begin
                    // r_fill doubles as the per-length counter here
                    if (r_rd_pend) begin
                        if (len_rdata > limit) r_bad <= 1'b1;
                        else if (len_rdata != 4'd0) begin
                            r_fill[len_rdata] <= r_fill[len_rdata] + (SymW+1)'(1);
                            r_present <= r_present + (SymW+1)'(1);
                        end
                    end
                    r_rd_pend <= (r_idx != r_n);
                    if (r_idx != r_n) r_idx <= r_idx + CntW'(1);
                    r_space <= 17'd1;
                    r_over  <= 1'b0;
                    r_len   <= 4'd1;
                    if (n_state == S_OUT) begin
                        r_status <= ST_BAD_SET;
                        r_load_cnt <= '0;
                    end
                end
                S_CHECK: begin
                    // r_len walks 1..15; tables built alongside
                    if (17'(r_fill[r_len]) > {r_space[15:0], 1'b0}) begin
                        r_over  <= 1'b1;
                        r_space <= '0;
                    end else begin
                        r_space <= {r_space[15:0], 1'b0} - 17'(r_fill[r_len]);
                    end
                    r_cnt[r_len]   <= r_fill[r_len][SymW-1:0];
                    r_first[r_len] <= (r_first[r_len-4'd1] + 16'(r_cnt[r_len-4'd1])) << 1;
                    r_slot[r_len]  <= r_slot[r_len-4'd1] + r_cnt[r_len-4'd1];
                    r_len <= r_len + 4'd1;
                    if (r_len == 4'd15) begin
                        r_idx     <= '0;
                        r_rd_pend <= 1'b0;
                    end
                end
                S_PLACE: begin
                    // first cycle: decide pass/fail, seed fill pointers
                    if (r_idx == '0 && !r_rd_pend) begin
                        for (int k = 1; k < 16; k++) r_fill[k] <= (SymW+1)'(r_slot[k]);
                        if (r_present >= (SymW+1)'(2) && (r_over || r_space != 17'd0)) begin
                            r_bad <= 1'b1;
                        end
                    end else if (r_len != 4'd0 && pfill < (SymW+1)'(MaxSymbols)) begin
                        r_fill[r_len] <= pfill + (SymW+1)'(1);
                    end
                    r_rd_pend <= (r_idx != r_n);
                    r_rsym    <= r_idx[SymW-1:0] - SymW'(1);
                    r_len     <= r_rd_pend ? len_rdata : 4'd0;
                    if (r_idx != r_n) r_idx <= r_idx + CntW'(1);
                    if (n_state == S_OUT) begin
                        r_load_cnt <= '0;
                        r_status   <= r_bad ? ST_BAD_SET : ST_OK;
                    end
                end
                S_DEC_RD: begin
                    r_code <= dcode;
                    r_len  <= r_len + 4'd1;
                    if (dhit) begin
                        r_ssl_ok <= dslot < SymW'(MaxSymbols);
                        r_used   <= r_len;
                        r_status <= ST_OK;
                    end else if (r_len == 4'(MaxLength)) begin
                        r_res       <= '{bits_used: 4'd1, symbol: '0, status: ST_INVALID};
                        r_out_valid <= 1'b1;
                    end
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    if (r_used != 4'd0 && r_status == ST_OK) begin
                        r_res <= '{bits_used: r_used, status: ST_OK,
                                   symbol: r_ssl_ok ? sym_rdata : '0};
                    end else begin
                        r_res <= '{bits_used: 4'd0, symbol: '0, status: r_status};
                        r_code_valid <= (r_status == ST_OK);
                    end
                    r_used <= 4'd0;
                end
                default: ;
            endcase
            if (r_state == S_IDLE && take) r_used <= 4'd0;
        end
    end
endmodule

// ===== rtl/canonical_huffman_build_decode_core.sv =====
// Canonical Huffman builder/decoder. Load words take one code length each; the word
// marked last builds the code with two passes over the length RAM plus a 15-step
// completeness check. A decode examines one code bit per cycle. Results leave through
// an output register; a two-word input queue accepts words while the core is busy,
// until it is full.
module canonical_huffman_build_decode_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,   // max_code_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata, // code_length[3:0], bit_window[18:4], pad
    input  logic        s_axis_tuser, // operation
    input  logic        s_axis_tlast, // last_length
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata  // status[2:0], symbol[11:3], bits_used[15:12]
);
    import chbd_pkg::*;

    t_item   in_item, q_item;
    t_result res;
    logic    q_valid, q_ready;

    assign in_item = '{op: s_axis_tuser, code_length: s_axis_tdata[3:0],
                       last_length: s_axis_tlast, bit_window: s_axis_tdata[18:4]};

    chbd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(in_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    chbd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {res.bits_used, res.symbol, res.status};
endmodule
